// ----- design/ledch_pkg.sv -----
// Package for the LED chaser with buzzer pattern.
// Holds the mode codes, register indexes, reset values and LED count.
// No dependencies.
`default_nettype none

package ledch_pkg;

	// Number of LEDs driven by the chaser; led_levels shows the lowest four.
	localparam int LED_NUM = 4;
	localparam int GS_W    = (LED_NUM > 2) ? $clog2(LED_NUM) : 1;
	localparam int LED_W   = (LED_NUM > 4) ? LED_NUM : 4;

	localparam int NUM_REGS = 8;
	localparam int REG_AW   = 3;
	localparam int TIMER_W  = 16;

	typedef enum logic [1:0] {
		LM_OFF    = 2'd0,
		LM_SINGLE = 2'd1,
		LM_DOUBLE = 2'd2,
		LM_FULL   = 2'd3
	} mode_t;

	typedef enum logic [REG_AW-1:0] {
		REG_SINGLE_ON    = 3'd0,
		REG_SINGLE_OFF   = 3'd1,
		REG_GROUP_ON     = 3'd2,
		REG_GROUP_OFF    = 3'd3,
		REG_BEEP_LONG_ON  = 3'd4,
		REG_BEEP_LONG_OFF = 3'd5,
		REG_BEEP_SHORT_ON = 3'd6,
		REG_BEEP_SHORT_OFF = 3'd7
	} reg_idx_t;

	typedef logic [TIMER_W-1:0] timer_t;

	function automatic timer_t reg_reset_value(input reg_idx_t idx);
		timer_t v;
		case (idx)
			REG_SINGLE_ON:      v = 16'd250;
			REG_SINGLE_OFF:     v = 16'd250;
			REG_GROUP_ON:       v = 16'd500;
			REG_GROUP_OFF:      v = 16'd500;
			REG_BEEP_LONG_ON:   v = 16'd200;
			REG_BEEP_LONG_OFF:  v = 16'd800;
			REG_BEEP_SHORT_ON:  v = 16'd50;
			REG_BEEP_SHORT_OFF: v = 16'd100;
			default:            v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- design/led_chaser_with_buzzer_pattern.sv -----
// LED chaser with buzzer pattern: top level; depends on ledch_pkg.
// The result of an accepted request is registered and shown on the master side in the next cycle.
// One request per cycle while results are taken; the result register frees as it is taken.
// The whole tick update is one pass of logic from the state registers into them.
// Reset (arst_n low) clears all state to idle, dark and silent, and loads the
// timing registers with their default periods.
`default_nettype none

module led_chaser_with_buzzer_pattern
	import ledch_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Tick requests.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [1:0] mode_request
	// Results.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // [3:0] led_levels, [4] buzzer_level
	// Configuration.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	timer_t             cfg_q [NUM_REGS];

	mode_t              active_q;
	logic [GS_W-1:0]    gs_q;
	logic               lph_q;
	timer_t             lt_left_q;
	logic               lt_arm_q;
	logic               bph_q;
	timer_t             bt_left_q;
	logic               bt_arm_q;
	logic [LED_NUM-1:0] led_q;
	logic               buzz_q;
	logic               m_valid_q;

	mode_t              req;
	logic               s_fire;

	mode_t              n_active;
	logic [GS_W-1:0]    n_gs;
	logic               n_lph;
	timer_t             n_lt_left;
	logic               n_lt_arm;
	logic               n_bph;
	timer_t             n_bt_left;
	logic               n_bt_arm;
	logic [LED_NUM-1:0] n_led;
	logic               n_buzz;

	timer_t             lt_tick;
	timer_t             bt_tick;
	logic               lt_fire;
	logic               bt_fire;
	logic               run_light;
	logic               run_beep;
	timer_t             l_on;
	timer_t             l_off;
	timer_t             b_on;
	timer_t             b_off;
	logic [LED_NUM-1:0] mask;
	logic [GS_W-1:0]    gs_adv;
	logic [GS_W:0]      gs_sum;
	logic [GS_W:0]      step_cnt;
	logic [LED_W-1:0]   led_ext;

	// Mask of count LEDs starting at first; positions past the end are dropped.
	function automatic logic [LED_NUM-1:0] group_mask(input logic [GS_W-1:0] first,
			input int count);
		logic [LED_NUM-1:0] m;
		for (int i = 0; i < LED_NUM; i++) begin
			m[i] = (i >= int'(first)) && (i < int'(first) + count);
		end
		return m;
	endfunction

	assign pready = 1'b1;
	assign prdata = {16'd0, cfg_q[paddr[4:2]]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= reg_reset_value(reg_idx_t'(i));
			end
		end else if (psel && penable && pwrite && pready) begin
			cfg_q[paddr[4:2]] <= pwdata[TIMER_W-1:0];
		end
	end

	assign req      = mode_t'(s_tdata[1:0]);
	assign s_tready = !m_valid_q || m_tready;
	assign s_fire   = s_tvalid && s_tready;

	// Timers count down at the start of every tick and are tested afterwards.
	assign lt_tick = (lt_arm_q && (lt_left_q != '0)) ? lt_left_q - 1'b1 : lt_left_q;
	assign bt_tick = (bt_arm_q && (bt_left_q != '0)) ? bt_left_q - 1'b1 : bt_left_q;
	assign lt_fire = lt_arm_q && (lt_tick == '0);
	assign bt_fire = bt_arm_q && (bt_tick == '0);

	always_comb begin
		run_light = 1'b0;
		run_beep  = 1'b0;
		l_on      = cfg_q[REG_GROUP_ON];
		l_off     = cfg_q[REG_GROUP_OFF];
		b_on      = cfg_q[REG_BEEP_LONG_ON];
		b_off     = cfg_q[REG_BEEP_LONG_OFF];
		mask      = '0;
		step_cnt  = (GS_W+1)'(1);
		case (active_q)
			LM_SINGLE: begin
				run_light = 1'b1;
				l_on      = cfg_q[REG_SINGLE_ON];
				l_off     = cfg_q[REG_SINGLE_OFF];
				mask      = group_mask(gs_q, 1);
			end
			LM_DOUBLE: begin
				run_light = 1'b1;
				run_beep  = 1'b1;
				mask      = group_mask(gs_q, 2);
				step_cnt  = (GS_W+1)'(2);
			end
			LM_FULL: begin
				run_light = 1'b1;
				run_beep  = 1'b1;
				b_on      = cfg_q[REG_BEEP_SHORT_ON];
				b_off     = cfg_q[REG_BEEP_SHORT_OFF];
				mask      = '1;
			end
			default: begin
				run_light = 1'b0;
			end
		endcase
	end

	// The whole row is lit in all mode, so the start always wraps back to zero there.
	assign gs_sum = {1'b0, gs_q} + step_cnt;
	assign gs_adv = ((active_q == LM_FULL) || (gs_sum >= (GS_W+1)'(LED_NUM))) ? '0
		: gs_sum[GS_W-1:0];

	always_comb begin
		n_active  = active_q;
		n_gs      = gs_q;
		n_lph     = lph_q;
		n_lt_left = lt_tick;
		n_lt_arm  = lt_arm_q;
		n_bph     = bph_q;
		n_bt_left = bt_tick;
		n_bt_arm  = bt_arm_q;
		n_led     = led_q;
		n_buzz    = buzz_q;
		if (req != active_q) begin
			n_active  = req;
			n_gs      = '0;
			n_lph     = 1'b0;
			n_led     = '0;
			n_buzz    = 1'b0;
			n_bph     = 1'b0;
			n_bt_left = timer_t'(1);
			n_bt_arm  = 1'b1;
			if (req != LM_OFF) begin
				n_lt_left = timer_t'(1);
				n_lt_arm  = 1'b1;
			end
		end else begin
			// A firing timer is always rearmed, so the armed flags keep their values here.
			if (run_light && lt_fire) begin
				if (!lph_q) begin
					n_led     = led_q | mask;
					n_lt_left = l_on;
					n_lph     = 1'b1;
				end else begin
					n_led     = led_q & ~mask;
					n_lt_left = l_off;
					n_lph     = 1'b0;
					n_gs      = gs_adv;
				end
			end
			if (run_beep && bt_fire) begin
				n_buzz    = !bph_q;
				n_bt_left = bph_q ? b_off : b_on;
				n_bph     = !bph_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= LM_OFF;
			gs_q      <= '0;
			lph_q     <= 1'b0;
			lt_left_q <= '0;
			lt_arm_q  <= 1'b0;
			bph_q     <= 1'b0;
			bt_left_q <= '0;
			bt_arm_q  <= 1'b0;
			led_q     <= '0;
			buzz_q    <= 1'b0;
		end else if (s_fire) begin
			active_q  <= n_active;
			gs_q      <= n_gs;
			lph_q     <= n_lph;
			lt_left_q <= n_lt_left;
			lt_arm_q  <= n_lt_arm;
			bph_q     <= n_bph;
			bt_left_q <= n_bt_left;
			bt_arm_q  <= n_bt_arm;
			led_q     <= n_led;
			buzz_q    <= n_buzz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// The LED and buzzer registers change only on a request, so they serve as
	// the result register.
	assign led_ext  = LED_W'(led_q);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'd0, buzz_q, led_ext[3:0]};

	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q == LM_OFF) |-> (led_q == '0))
		else $error("LEDs lit while idle");

	a_buzz_mode: assert property (@(posedge clk) disable iff (!arst_n)
		buzz_q |-> ((active_q == LM_DOUBLE) || (active_q == LM_FULL)))
		else $error("buzzer sounding in a mode without a beep pattern");

	a_single_one: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q == LM_SINGLE) |-> ($countones(led_q) <= 1))
		else $error("more than one LED lit in single mode");

	a_change_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && (req != active_q)) |=> (m_tdata[4:0] == 5'd0))
		else $error("mode change did not darken and silence the outputs");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |-> !s_tready)
		else $error("request taken while a result is stalled");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the LED chaser with buzzer pattern.
// Predicts LED and buzzer levels per tick and checks every result.
// Depends on ledch_pkg and led_chaser_with_buzzer_pattern.
`timescale 1ns / 100ps

module tb_top;
	import ledch_pkg::*;

	typedef struct packed {
		logic [3:0] leds;
		logic       buzz;
	} lamp_state_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [1:0] mode_request
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;           // [3:0] led_levels, [4] buzzer_level
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = 5'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	led_chaser_with_buzzer_pattern dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow of the timing registers and of the chaser state.
	timer_t timing_shadow [NUM_REGS] = '{250, 250, 500, 500, 200, 800, 50, 100};
	mode_t             cur_mode = LM_OFF;
	int                grp_first = 0;
	logic              light_on = 1'b0;
	timer_t            light_left = '0;
	logic              light_armed = 1'b0;
	logic              beep_on = 1'b0;
	timer_t            beep_left = '0;
	logic              beep_armed = 1'b0;
	logic [LED_W-1:0]  led_reg = '0;
	logic              buzz_reg = 1'b0;

	lamp_state_t pending_levels [$];
	int          mismatch_count = 0;
	int          send_idle_pct = 0;
	int          hold_pct = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic report_mismatch(string what, int unsigned want, int unsigned got);
		mismatch_count++;
		$display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
	endtask

	function automatic logic [LED_W-1:0] span_mask(int first, int count);
		logic [LED_W-1:0] m;
		m = '0;
		for (int g = 0; g < count; g++)
			if (first + g < LED_NUM)
				m[first + g] = 1'b1;
		return m;
	endfunction

	function automatic void step_lights(int first, int count, timer_t on_t, timer_t off_t);
		int nxt;
		if (!(light_armed && light_left == 0))
			return;
		light_armed = 1'b1;
		if (!light_on) begin
			led_reg |= span_mask(first, count);
			light_left = on_t;
			light_on = 1'b1;
		end else begin
			led_reg &= ~span_mask(first, count);
			light_left = off_t;
			light_on = 1'b0;
			nxt = grp_first + count;
			grp_first = (nxt >= LED_NUM) ? 0 : nxt;
		end
	endfunction

	function automatic void step_beep(timer_t on_t, timer_t off_t);
		if (!(beep_armed && beep_left == 0))
			return;
		beep_armed = 1'b1;
		buzz_reg = !beep_on;
		beep_left = beep_on ? off_t : on_t;
		beep_on = !beep_on;
	endfunction

	// One millisecond tick: both timers count down, then either a mode change
	// restarts the pattern or the active mode runs its timers.
	function automatic lamp_state_t advance_chaser(mode_t req);
		lamp_state_t lv;
		if (light_armed && light_left != 0)
			light_left--;
		if (beep_armed && beep_left != 0)
			beep_left--;
		if (req != cur_mode) begin
			buzz_reg = 1'b0;
			beep_on = 1'b0;
			beep_left = 16'd1;
			beep_armed = 1'b1;
			cur_mode = req;
			grp_first = 0;
			light_on = 1'b0;
			led_reg = '0;
			if (req != LM_OFF) begin
				light_left = 16'd1;
				light_armed = 1'b1;
			end
		end else begin
			case (cur_mode)
				LM_SINGLE: begin
					step_lights(grp_first, 1, timing_shadow[REG_SINGLE_ON],
						timing_shadow[REG_SINGLE_OFF]);
				end
				LM_DOUBLE: begin
					step_lights(grp_first, 2, timing_shadow[REG_GROUP_ON],
						timing_shadow[REG_GROUP_OFF]);
					step_beep(timing_shadow[REG_BEEP_LONG_ON], timing_shadow[REG_BEEP_LONG_OFF]);
				end
				LM_FULL: begin
					step_lights(0, LED_NUM, timing_shadow[REG_GROUP_ON],
						timing_shadow[REG_GROUP_OFF]);
					step_beep(timing_shadow[REG_BEEP_SHORT_ON],
						timing_shadow[REG_BEEP_SHORT_OFF]);
				end
				default: begin
				end
			endcase
		end
		lv.leds = led_reg[3:0];
		lv.buzz = buzz_reg;
		return lv;
	endfunction

	// Requests are predicted before results are checked, so a result taken in the
	// same cycle as its request would still find its expectation.
	always @(posedge clk) begin
		lamp_state_t want;
		if (s_tvalid && s_tready)
			pending_levels.push_back(advance_chaser(mode_t'(s_tdata[1:0])));
		if (m_tvalid && m_tready) begin
			if (pending_levels.size() == 0) begin
				report_mismatch("unexpected result", 0, m_tdata);
			end else begin
				want = pending_levels.pop_front();
				if (m_tdata[3:0] !== want.leds)
					report_mismatch("led_levels", want.leds, m_tdata[3:0]);
				if (m_tdata[4] !== want.buzz)
					report_mismatch("buzzer_level", want.buzz, m_tdata[4]);
			end
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= hold_pct);

	task automatic send_tick(mode_t m);
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, m};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic settle_traffic();
		s_tvalid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic apb_access(reg_idx_t idx, logic wr, timer_t val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		if (wr)
			pwdata <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (wr)
			timing_shadow[idx] = val;
		else if (prdata !== {16'b0, timing_shadow[idx]})
			report_mismatch("register readback", timing_shadow[idx], prdata);
	endtask

	// Reads back the current settings, writes the new ones and reads them again.
	// Only called while the block is idle.
	task automatic program_timing(timer_t vals [NUM_REGS]);
		for (int i = 0; i < NUM_REGS; i++)
			apb_access(reg_idx_t'(i), 1'b0, '0);
		for (int i = 0; i < NUM_REGS; i++)
			apb_access(reg_idx_t'(i), 1'b1, vals[i]);
		for (int i = 0; i < NUM_REGS; i++)
			apb_access(reg_idx_t'(i), 1'b0, '0);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic timer_t pick_period();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 16'hFFFF;
		if (r == 1)
			return 16'd0;
		return timer_t'($urandom_range(1, 7));
	endfunction

	// A zero period behaves like one, so every timer expires on each tick and
	// the lights and the buzzer step as fast as they can.
	task automatic test_zero_periods();
		timer_t vals [NUM_REGS];
		mode_t seq [$];
		foreach (vals[i])
			vals[i] = '0;
		program_timing(vals);
		seq = {LM_OFF, LM_OFF};
		repeat (6) seq.push_back(LM_SINGLE);
		repeat (7) seq.push_back(LM_DOUBLE);
		repeat (7) seq.push_back(LM_FULL);
		seq.push_back(LM_OFF);
		seq.push_back(LM_OFF);
		foreach (seq[i])
			send_tick(seq[i]);
		settle_traffic();
	endtask

	task automatic test_longest_periods();
		timer_t vals [NUM_REGS];
		foreach (vals[i])
			vals[i] = 16'hFFFF;
		program_timing(vals);
		repeat (3) send_tick(LM_DOUBLE);
		settle_traffic();
	endtask

	// Mostly long runs of one mode so that the patterns wrap, with some quick
	// mode flips in between.
	task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
		timer_t vals [NUM_REGS];
		int sent;
		int len;
		mode_t m;
		foreach (vals[i])
			vals[i] = pick_period();
		program_timing(vals);
		send_idle_pct = idle_pct;
		hold_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			m = mode_t'($urandom_range(0, 3));
			if ($urandom_range(0, 9) < 2)
				len = $urandom_range(1, 3);
			else
				len = $urandom_range(8, 48);
			repeat (len) begin
				send_tick(m);
				sent++;
			end
		end
		settle_traffic();
		send_idle_pct = 0;
		hold_pct = 0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_zero_periods();
		test_longest_periods();
		test_random_traffic(0, 0, 156);
		test_random_traffic(56, 0, 156);
		test_random_traffic(0, 56, 156);
		test_random_traffic(24, 24, 156);
		if (pending_levels.size() != 0)
			report_mismatch("results still missing", pending_levels.size(), 0);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
